// ===== sv/tfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfc_pkg
// Shared widths, constants and item types for the tolerant float compare.
// ----------------------------------------------------------------------------
package tfc_pkg;

  localparam int unsigned FW = 32;
  localparam int unsigned UW = 31;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_EPSILON = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ULPS    = 1'd1;

  localparam logic [FW-1:0] EPS_RESET  = 32'h3400_0000;
  localparam logic [UW-1:0] ULPS_RESET = 31'd4;
  localparam logic [UW-1:0] ULPS_MAX   = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [FW-1:0] operand_a;
    logic [FW-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic          is_equal;
    logic          is_less;
    logic          is_greater;
    logic [UW-1:0] ulps_apart;
  } out_item_t;

endpackage

// ===== sv/tfc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfc_in_if / tfc_out_if
// Valid/ready channels carrying input and result items.
// ----------------------------------------------------------------------------
interface tfc_in_if;
  logic               valid;
  logic               ready;
  tfc_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tfc_out_if;
  logic               valid;
  logic               ready;
  tfc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/tolerant_float_compare.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tolerant_float_compare
// Tolerant equality / ordering of two IEEE single operands (ULP and epsilon).
// ----------------------------------------------------------------------------
// channel | dir | payload
// in_ch   | in  | operand_a[31:0], operand_b[31:0]
// out_ch  | out | is_equal, is_less, is_greater, ulps_apart[30:0]
// cfg_*   | in  | cfg_we, cfg_idx[0], cfg_data[31:0]
//
// Four register stages, one item per cycle while the output is not stalled.
// Stage 1 classifies and aligns, stage 2 adds mantissas, stage 3 normalizes
// and rounds the difference, stage 4 compares and decides. Synchronous
// active-low reset clears valid bits and restores the configuration
// registers. A stall at the output holds every stage in place (global
// enable).
// ----------------------------------------------------------------------------
module tolerant_float_compare (
  input  logic                               clk,
  input  logic                               rst_n,
  tfc_in_if.sink                             in_ch,
  tfc_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [tfc_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [tfc_pkg::FW-1:0]             cfg_data
);

  logic [31:0] eps_r;
  logic [30:0] ulim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r  <= tfc_pkg::EPS_RESET;
      ulim_r <= tfc_pkg::ULPS_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        tfc_pkg::REG_EPSILON: eps_r  <= cfg_data;
        tfc_pkg::REG_ULPS:    ulim_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  logic [3:0] v_r;
  logic       en;
  assign en = !v_r[3] || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------- stage 1: classify, ulp distance, align ----------------
  logic [31:0] a, b;
  assign a = in_ch.data.operand_a;
  assign b = in_ch.data.operand_b;

  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, ieq, unord, lt_ord;
  logic [32:0] dab;
  logic [31:0] dist_full;
  logic [30:0] dist_nxt;
  always_comb begin
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    a_zero = a[30:0] == '0;
    b_zero = b[30:0] == '0;
    unord  = a_nan || b_nan;
    ieq    = !unord && ((a == b) || (a_zero && b_zero));
    if (a_zero && b_zero) lt_ord = 1'b0;
    else if (a[31] != b[31]) lt_ord = a[31];
    else if (a[31]) lt_ord = a[30:0] > b[30:0];
    else lt_ord = a[30:0] < b[30:0];
    lt_ord = lt_ord && !unord;
    dab = {1'b0, a} - {1'b0, b};
    dist_full = dab[32] ? (b - a) : dab[31:0];
    if (ieq) dist_nxt = '0;
    else if (unord || a_inf || b_inf || (a[31] != b[31])) dist_nxt = tfc_pkg::ULPS_MAX;
    else dist_nxt = dist_full[30:0];
  end

  // subtraction operands: effective a + (-b); order by magnitude
  logic        sb;
  logic        swap;
  logic [31:0] xa, xb;
  logic [7:0]  ex_big, ex_sml, dexp;
  logic [26:0] m_big, m_sml, m_sh;
  logic        eff_sub, sticky;
  logic [26:0] mask;
  always_comb begin
    sb   = ~b[31];
    swap = b[30:0] > a[30:0];
    xa   = swap ? {sb, b[30:0]} : a;
    xb   = swap ? a : {sb, b[30:0]};
    eff_sub = xa[31] != xb[31];
    ex_big = (xa[30:23] == '0) ? 8'd1 : xa[30:23];
    ex_sml = (xb[30:23] == '0) ? 8'd1 : xb[30:23];
    m_big  = {(xa[30:23] != '0), xa[22:0], 3'b000};
    m_sml  = {(xb[30:23] != '0), xb[22:0], 3'b000};
    dexp   = ex_big - ex_sml;
    mask   = ~(27'h7FF_FFFF << dexp[4:0]);
    if (dexp > 8'd26) begin
      m_sh = '0;
      sticky = m_sml != '0;
    end else begin
      m_sh = m_sml >> dexp[4:0];
      sticky = (m_sml & mask) != '0;
    end
    m_sh[0] = m_sh[0] | sticky;
  end

  logic        s1_spec_r, s1_unord_r, s1_lt_r, s1_sub_r;
  logic [7:0]  s1_ex_r;
  logic [26:0] s1_mb_r, s1_ms_r;
  logic [30:0] s1_dist_r;
  logic        s1_inf_r, s1_ieq_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_unord_r <= unord;
      s1_inf_r   <= a_inf || b_inf;
      s1_ieq_r   <= ieq;
      s1_lt_r    <= lt_ord;
      s1_sub_r   <= eff_sub;
      s1_ex_r    <= ex_big;
      s1_mb_r    <= m_big;
      s1_ms_r    <= m_sh;
      s1_dist_r  <= dist_nxt;
      s1_spec_r  <= unord || a_inf || b_inf;
    end
  end

  // ---------------- stage 2: add / subtract mantissas ----------------
  logic [27:0] sum_nxt;
  assign sum_nxt = s1_sub_r ? ({1'b0, s1_mb_r} - {1'b0, s1_ms_r})
                            : ({1'b0, s1_mb_r} + {1'b0, s1_ms_r});

  logic [27:0] s2_sum_r;
  logic [7:0]  s2_ex_r;
  logic        s2_spec_r, s2_nan_r, s2_lt_r;
  logic [30:0] s2_dist_r;
  // infinite - infinite of like magnitude sign gives NaN
  logic        s2_infnan_nxt;
  assign s2_infnan_nxt = s1_unord_r || (s1_inf_r && s1_ieq_r == 1'b0 && s1_sub_r
                         && s1_ms_r == s1_mb_r) || (s1_inf_r && s1_ieq_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sum_r  <= sum_nxt;
      s2_ex_r   <= s1_ex_r;
      s2_spec_r <= s1_spec_r;
      s2_nan_r  <= s2_infnan_nxt;
      s2_lt_r   <= s1_lt_r;
      s2_dist_r <= s1_dist_r;
    end
  end

  // ---------------- stage 3: normalize and round magnitude ----------------
  logic [4:0]  lz;
  logic [27:0] nm;
  logic [8:0]  ex_n;
  logic [23:0] mant;
  logic        rnd;
  logic [24:0] mr;
  logic [8:0]  ex_r9;
  logic [30:0] mag_nxt;
  always_comb begin
    lz = 5'd27;
    for (int i = 0; i <= 26; i++) begin
      if (s2_sum_r[i]) lz = 5'(26 - i);
    end
    if (s2_sum_r[27]) begin
      nm   = {1'b0, s2_sum_r[27:2], s2_sum_r[1] | s2_sum_r[0]};
      ex_n = {1'b0, s2_ex_r} + 9'd1;
    end else if (s2_sum_r == '0 || {4'd0, lz} >= {1'b0, s2_ex_r} - 9'd1
                 || s2_ex_r <= 8'd1) begin
      nm   = s2_sum_r << (s2_ex_r - 8'd1);
      ex_n = 9'd0;
    end else begin
      nm   = s2_sum_r << lz;
      ex_n = {1'b0, s2_ex_r} - {4'd0, lz};
    end
    mant = nm[26:3];
    rnd  = nm[2] && (nm[1] || nm[0] || nm[3]);
    mr   = {1'b0, mant} + {24'd0, rnd};
    ex_r9 = ex_n;
    if (ex_n == 9'd0 && mr[23]) ex_r9 = 9'd1;
    if (mr[24]) begin
      ex_r9 = ex_n + 9'd1;
      mr    = mr >> 1;
    end
    if (ex_r9 >= 9'd255) mag_nxt = {8'hFF, 23'd0};
    else mag_nxt = {ex_r9[7:0], mr[22:0]};
  end

  logic [30:0] s3_mag_r, s3_dist_r;
  logic        s3_nan_r, s3_lt_r, s3_spec_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s3_mag_r  <= mag_nxt;
      s3_nan_r  <= s2_nan_r;
      s3_spec_r <= s2_spec_r;
      s3_lt_r   <= s2_lt_r;
      s3_dist_r <= s2_dist_r;
    end
  end

  // ---------------- stage 4: decide ----------------
  logic [30:0] magv;
  logic        eps_nan, eps_ok, eq4;
  tfc_pkg::out_item_t res_nxt, res_r;
  always_comb begin
    magv = s3_spec_r ? {8'hFF, 23'd0} : s3_mag_r;
    eps_nan = (eps_r[30:23] == 8'hFF) && (eps_r[22:0] != '0);
    // negative epsilon only admits a zero difference, and only when it is -0
    eps_ok = !s3_nan_r && !eps_nan &&
             (eps_r[31] ? (magv == '0 && eps_r[30:0] == '0) : (magv <= eps_r[30:0]));
    eq4 = eps_ok || (s3_dist_r <= ulim_r);
    res_nxt.is_equal   = eq4;
    res_nxt.is_less    = !eq4 && s3_lt_r;
    res_nxt.is_greater = !eq4 && !s3_lt_r;
    res_nxt.ulps_apart = s3_dist_r;
  end

  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_ch.valid};
    end
  end

  assign out_ch.valid = v_r[3];
  assign out_ch.data  = res_r;

`ifndef ASSERT_OFF
  a_onehot_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> $onehot({res_r.is_equal, res_r.is_less, res_r.is_greater}))
    else $error("result flags not one-hot");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(res_r)))
    else $error("result changed under stall");
  a_zero_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && res_r.ulps_apart == '0) |-> res_r.is_equal)
    else $error("zero distance not equal");
`endif

endmodule

// ===== verif/tfc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfc_checker
// Watches the operand and result channels of the tolerant float compare,
// computes the expected decision and ULP distance for every accepted operand
// pair, and compares each result item with the oldest pending expectation.
// Register writes are snooped so the prediction tracks the live settings.
// ----------------------------------------------------------------------------
module tfc_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  tfc_in_if                             in_ch,
  tfc_out_if                            out_ch,
  input  logic                          cfg_we,
  input  logic [tfc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [tfc_pkg::FW-1:0]        cfg_data,
  output int                            fail_count,
  output int                            pending_count
);

  logic [tfc_pkg::FW-1:0]   eps_reg;
  logic [tfc_pkg::UW-1:0]   ulps_reg;
  tfc_pkg::out_item_t       verdict_q[$];

  function automatic bit is_nan32(logic [31:0] v);
    return v[30:23] == 8'hFF && v[22:0] != 0;
  endfunction

  function automatic bit is_inf32(logic [31:0] v);
    return v[30:23] == 8'hFF && v[22:0] == 0;
  endfunction

  // finite float bits to real, exact
  function automatic real float_val(logic [31:0] v);
    real r;
    if (v[30:23] == 0) begin
      r = real'(v[22:0]) * $bitstoreal({1'b0, 11'(1023 - 149), 52'b0});
      return v[31] ? -r : r;
    end
    return $bitstoreal({v[31], 11'(int'(v[30:23]) - 127 + 1023), v[22:0], 29'b0});
  endfunction

  // round a real to single precision, nearest even
  function automatic logic [31:0] round_single(real x);
    logic [63:0] b;
    logic [63:0] sig;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    int          ex;
    int          shift;
    b = $realtobits(x);
    if (b[62:52] == 0) return {b[63], 31'b0};
    ex = int'(b[62:52]) - 1023;
    if (ex > 127) return {b[63], 8'hFF, 23'b0};
    sig = {11'b0, 1'b1, b[51:0]};
    shift = (ex >= -126) ? 29 : 29 + (-126 - ex);
    if (shift > 60) return {b[63], 31'b0};
    kept = sig >> shift;
    rem = sig & ((64'd1 << shift) - 1);
    half = 64'd1 << (shift - 1);
    if (rem > half || (rem == half && kept[0])) kept = kept + 1;
    if (ex >= -126) begin
      if (kept == (64'd1 << 24)) begin
        kept = 64'd1 << 23;
        ex = ex + 1;
      end
      if (ex > 127) return {b[63], 8'hFF, 23'b0};
      return {b[63], 8'(ex + 127), kept[22:0]};
    end
    return {b[63], 8'(kept >> 23), kept[22:0]};
  endfunction

  function automatic tfc_pkg::out_item_t judge_pair(logic [31:0] a, logic [31:0] b);
    tfc_pkg::out_item_t r;
    logic [31:0] mag;
    logic [31:0] d;
    bit          nan_any;
    bit          same;
    bit          eps_ok;
    bit          below;
    nan_any = is_nan32(a) || is_nan32(b);
    // same value under IEEE compare
    if (nan_any) same = 0;
    else if (is_inf32(a) || is_inf32(b)) same = (a == b);
    else same = (float_val(a) == float_val(b));
    if (same) d = 0;
    else if (nan_any || is_inf32(a) || is_inf32(b) || a[31] != b[31])
      d = {1'b0, tfc_pkg::ULPS_MAX};
    else d = (a > b) ? a - b : b - a;
    // magnitude of a - b
    if (nan_any || (is_inf32(a) && is_inf32(b) && a[31] == b[31])) mag = 32'h7FC0_0000;
    else if (is_inf32(a) || is_inf32(b)) mag = 32'h7F80_0000;
    else mag = round_single(float_val(a) - float_val(b)) & 32'h7FFF_FFFF;
    if (is_nan32(mag) || is_nan32(eps_reg)) eps_ok = 0;
    else if (is_inf32(eps_reg)) eps_ok = !eps_reg[31];
    else if (is_inf32(mag)) eps_ok = 0;
    else eps_ok = float_val(mag) <= float_val(eps_reg);
    if (nan_any) below = 0;
    else if (is_inf32(a) || is_inf32(b)) below = !same && ((is_inf32(a) && a[31]) ||
                                                           (is_inf32(b) && !b[31]));
    else below = float_val(a) < float_val(b);
    r.is_equal   = eps_ok || (d[tfc_pkg::UW-1:0] <= ulps_reg);
    r.is_less    = !r.is_equal && below;
    r.is_greater = !r.is_equal && !r.is_less;
    r.ulps_apart = d[tfc_pkg::UW-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    tfc_pkg::out_item_t want;
    tfc_pkg::out_item_t got;
    if (!rst_n) begin
      eps_reg <= tfc_pkg::EPS_RESET;
      ulps_reg <= tfc_pkg::ULPS_RESET;
      verdict_q.delete();
      fail_count <= 0;
      pending_count <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result item %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = verdict_q.pop_front();
          if (got.is_equal !== want.is_equal || got.is_less !== want.is_less ||
              got.is_greater !== want.is_greater || got.ulps_apart !== want.ulps_apart) begin
            $display("%0t: mismatch eq/lt/gt/ulps expected %b%b%b %h actual %b%b%b %h",
                     $time, want.is_equal, want.is_less, want.is_greater, want.ulps_apart,
                     got.is_equal, got.is_less, got.is_greater, got.ulps_apart);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        verdict_q.push_back(judge_pair(in_ch.data.operand_a, in_ch.data.operand_b));
      if (cfg_we) begin
        if (cfg_idx == tfc_pkg::REG_EPSILON) eps_reg <= cfg_data;
        else if (cfg_idx == tfc_pkg::REG_ULPS) ulps_reg <= cfg_data[tfc_pkg::UW-1:0];
      end
      pending_count <= verdict_q.size();
    end
  end

endmodule

// ===== verif/tb_tolerant_float_compare.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tolerant_float_compare
// Drives operand pairs with random gaps and result back-pressure through
// several tolerance settings, including the extremes; a checker beside the
// block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_tolerant_float_compare;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [tfc_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [tfc_pkg::FW-1:0]        cfg_data;
  int                            fail_count;
  int                            pending_count;
  bit                            no_idle;

  tfc_in_if  in_ch();
  tfc_out_if out_ch();

  tolerant_float_compare i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  tfc_checker i_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("tb_tolerant_float_compare: FAIL");
    $finish;
  end

  // result side back-pressure
  initial begin
    out_ch.ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!no_idle) begin
        out_ch.ready = 0;
        repeat ($urandom_range(0, 9)) @(negedge clk);
      end
      out_ch.ready = 1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  task automatic send_pair(logic [31:0] a, logic [31:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1;
    in_ch.data.operand_a = a;
    in_ch.data.operand_b = b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    in_ch.valid = 0;
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [tfc_pkg::CFG_IDX_W-1:0] idx, logic [tfc_pkg::FW-1:0] val);
    cfg_we = 1;
    cfg_idx = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  function automatic logic [31:0] special_val();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7F80_0000;
      3: return 32'hFF80_0000;
      4: return {1'($urandom_range(0, 1)), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
      5: return 32'h7F7F_FFFF;
      6: return 32'hFF7F_FFFF;
      7: return {1'($urandom_range(0, 1)), 8'h00, 23'($urandom())};
      8: return 32'h3400_0000;
      default: return {1'($urandom_range(0, 1)), 31'($urandom_range(0, 7))};
    endcase
  endfunction

  task automatic random_pair;
    logic [31:0] a;
    logic [31:0] b;
    a = $urandom();
    case ($urandom_range(0, 7))
      0: b = $urandom();
      1: begin a = special_val(); b = $urandom_range(0, 1) ? special_val() : $urandom(); end
      2: b = a + $urandom_range(0, 12);
      3: b = a - $urandom_range(0, 12);
      4: b = {a[31:23], 23'($urandom())};
      5: b = a ^ 32'h8000_0000;
      6: begin a = {a[31], 8'($urandom_range(100, 140)), a[22:0]};
               b = {1'($urandom_range(0, 1)), 8'($urandom_range(100, 140)),
                    23'($urandom())}; end
      default: b = a + ($urandom_range(0, 1) ? 32'd1 << $urandom_range(0, 30) : 32'd0);
    endcase
    if ($urandom_range(0, 1)) send_pair(a, b);
    else send_pair(b, a);
  endtask

  logic [31:0] eps_set[6]  = '{tfc_pkg::EPS_RESET, 32'h0000_0000, 32'hFFFF_FFFF,
                               32'h7F7F_FFFF, 32'h8000_0000, 32'h7F80_0000};
  logic [31:0] ulps_set[6] = '{32'(tfc_pkg::ULPS_RESET), 32'd0, 32'(tfc_pkg::ULPS_MAX),
                               32'd1000, 32'h7FFF_FFFE, 32'd1};

  initial begin
    rst_n = 0;
    cfg_we = 0;
    cfg_idx = tfc_pkg::REG_EPSILON;
    cfg_data = 0;
    in_ch.valid = 0;
    in_ch.data = '0;
    no_idle = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed corners at reset settings
    send_pair(32'h0000_0000, 32'h8000_0000);
    send_pair(32'h3F80_0000, 32'h3F80_0000);
    send_pair(32'h3F80_0000, 32'h3F80_0004);
    send_pair(32'h3F80_0000, 32'h3F80_0005);
    send_pair(32'h3F80_0005, 32'h3F80_0000);
    send_pair(32'h7FC0_0000, 32'h3F80_0000);
    send_pair(32'h3F80_0000, 32'hFFC0_0001);
    send_pair(32'h7F80_0000, 32'h7F80_0000);
    send_pair(32'hFF80_0000, 32'h7F80_0000);
    send_pair(32'h7F80_0000, 32'hFF80_0000);
    send_pair(32'h7F80_0000, 32'h7F7F_FFFF);
    send_pair(32'h7F7F_FFFF, 32'hFF7F_FFFF);
    send_pair(32'h0000_0001, 32'h8000_0001);
    send_pair(32'h3400_0000, 32'h0000_0000);
    send_pair(32'h3400_0001, 32'h0000_0000);
    send_pair(32'hBF80_0000, 32'h3F80_0000);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'h0000_0000, 32'hFFFF_FFFF);
    send_pair(32'h007F_FFFF, 32'h0080_0000);

    for (int p = 0; p < 6; p++) begin
      drain();
      write_reg(tfc_pkg::REG_EPSILON, eps_set[p]);
      write_reg(tfc_pkg::REG_ULPS, ulps_set[p]);
      no_idle = (p == 3);
      if (p == 2) begin
        send_pair(32'h7FC0_0000, 32'h0000_0000);
        send_pair(32'hFF80_0000, 32'h7F80_0000);
      end
      for (int i = 0; i < 330; i++) random_pair();
    end
    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("tb_tolerant_float_compare: PASS");
    else
      $display("tb_tolerant_float_compare: FAIL");
    $finish;
  end

endmodule
